// ===== design/epi_pkg.sv =====
// Shared constants and types for the edge plane intersect unit.
`timescale 1ns / 1ps
package epi_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CoordW          = 32;
  localparam int unsigned TolW            = 31;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned SideW           = 2;
  // Plane values: three floored products of up to 2^62 / 2^16 each, plus d.
  localparam int unsigned PlaneW          = 58;
  localparam int unsigned QueueDepth      = 4;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegNormalX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNormalY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNormalZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffset  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTol     = 3'd4;

  // Result side codes.
  localparam logic [SideW-1:0] SideNone = 2'd0;
  localparam logic [SideW-1:0] SideNeg  = 2'd1;
  localparam logic [SideW-1:0] SidePos  = 2'd2;

  // What the back part must do with an item.
  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindEnd   = 2'd1,
    KindCross = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] sz;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ez;
  } edge_t;

  typedef struct packed {
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] d;
    logic [TolW-1:0]          tol;
  } plane_t;

endpackage

// ===== design/epi_if.sv =====
// Valid/ready channel interface for edge, result and configuration transfers.
`timescale 1ns / 1ps
interface epi_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/epi_front.sv =====
// Front part: plane evaluation at both ends and classification, pipelined.
`timescale 1ns / 1ps
module epi_front #(
  parameter int unsigned FracBits = epi_pkg::FracBitsDefault,
  parameter int unsigned NumW     = epi_pkg::PlaneW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  epi_pkg::plane_t      plane_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  epi_pkg::edge_t       in_edge_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output epi_pkg::edge_t       out_edge_o,
  output epi_pkg::kind_e       out_kind_o,
  output logic [epi_pkg::SideW-1:0] out_side_o,
  output logic [NumW-1:0]      out_num_o,
  output logic [NumW-1:0]      out_den_o
);
  localparam int unsigned PW = epi_pkg::PlaneW;
  localparam int unsigned MW = 2 * epi_pkg::CoordW;

  // Stage 1: six products. Stage 2: sums and classification.
  logic                      v1_q, v2_q;
  logic                      adv1, adv2;
  epi_pkg::edge_t            e1_q, e2_q;
  logic signed [MW-1:0]      p_q [6];
  logic signed [PW-1:0]      vs, ve;
  logic signed [PW-1:0]      tol_s;
  logic                      s_neg, s_pos, e_neg, e_pos;
  logic [PW-1:0]             abs_s, abs_e;
  epi_pkg::kind_e            kind_d, kind_q;
  logic [epi_pkg::SideW-1:0] side_d, side_q;
  logic [NumW-1:0]           num_q, den_q;

  assign adv2       = !v2_q || out_ready_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      e1_q <= in_edge_i;
      p_q[0] <= MW'(plane_i.nx) * MW'(in_edge_i.sx);
      p_q[1] <= MW'(plane_i.ny) * MW'(in_edge_i.sy);
      p_q[2] <= MW'(plane_i.nz) * MW'(in_edge_i.sz);
      p_q[3] <= MW'(plane_i.nx) * MW'(in_edge_i.ex);
      p_q[4] <= MW'(plane_i.ny) * MW'(in_edge_i.ey);
      p_q[5] <= MW'(plane_i.nz) * MW'(in_edge_i.ez);
    end
  end

  always_comb begin
    vs = PW'(p_q[0] >>> FracBits) + PW'(p_q[1] >>> FracBits)
       + PW'(p_q[2] >>> FracBits) + PW'(plane_i.d);
    ve = PW'(p_q[3] >>> FracBits) + PW'(p_q[4] >>> FracBits)
       + PW'(p_q[5] >>> FracBits) + PW'(plane_i.d);
    tol_s = signed'(PW'(plane_i.tol));
    s_neg = vs < -tol_s;
    s_pos = vs > tol_s;
    e_neg = ve < -tol_s;
    e_pos = ve > tol_s;
    abs_s = vs[PW-1] ? PW'(-vs) : PW'(vs);
    abs_e = ve[PW-1] ? PW'(-ve) : PW'(ve);
    side_d = s_neg ? epi_pkg::SideNeg : epi_pkg::SidePos;
    if (!s_neg && !s_pos) begin
      kind_d = epi_pkg::KindNone;
      side_d = epi_pkg::SideNone;
    end else if (!e_neg && !e_pos) begin
      kind_d = epi_pkg::KindEnd;
    end else if ((s_neg && e_pos) || (s_pos && e_neg)) begin
      kind_d = epi_pkg::KindCross;
    end else begin
      kind_d = epi_pkg::KindNone;
      side_d = epi_pkg::SideNone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      e2_q   <= e1_q;
      kind_q <= kind_d;
      side_q <= side_d;
      num_q  <= NumW'(abs_s);
      den_q  <= NumW'(abs_s) + NumW'(abs_e);
    end
  end

  assign out_valid_o = v2_q;
  assign out_edge_o  = e2_q;
  assign out_kind_o  = kind_q;
  assign out_side_o  = side_q;
  assign out_num_o   = num_q;
  assign out_den_o   = den_q;
endmodule

// ===== design/epi_queue.sv =====
// Short first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps
module epi_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = epi_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
endmodule

// ===== design/epi_back.sv =====
// Back part: pipelined restoring divider, interpolation and output register.
`timescale 1ns / 1ps
module epi_back #(
  parameter int unsigned FracBits = epi_pkg::FracBitsDefault,
  parameter int unsigned NumW     = epi_pkg::PlaneW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  epi_pkg::edge_t       in_edge_i,
  input  epi_pkg::kind_e       in_kind_i,
  input  logic [epi_pkg::SideW-1:0] in_side_i,
  input  logic [NumW-1:0]      in_num_i,
  input  logic [NumW-1:0]      in_den_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [epi_pkg::SideW-1:0] out_side_o,
  output logic signed [epi_pkg::CoordW-1:0] out_x_o,
  output logic signed [epi_pkg::CoordW-1:0] out_y_o,
  output logic signed [epi_pkg::CoordW-1:0] out_z_o
);
  localparam int unsigned CW = epi_pkg::CoordW;
  localparam int unsigned NS = FracBits;   // one quotient bit per stage
  localparam int unsigned DW = CW + 1;     // coordinate difference
  localparam int unsigned MW = DW + FracBits + 1;

  logic                       adv [NS+3];
  logic                       vld_q [NS+3];
  epi_pkg::edge_t             ed_q [NS+1];
  epi_pkg::kind_e             kd_q [NS+1];
  logic [epi_pkg::SideW-1:0]  sd_q [NS+1];
  logic [NumW-1:0]            r_q [NS+1];
  logic [NumW-1:0]            dn_q [NS+1];
  logic [FracBits-1:0]        qt_q [NS+1];

  // Stage index 0 is the entry register, 1..NS divider steps,
  // NS+1 products, NS+2 output register.
  assign adv[NS+2] = !vld_q[NS+2] || out_ready_i;
  for (genvar g = 0; g <= NS + 1; g++) begin : g_adv
    assign adv[g] = !vld_q[g] || adv[g+1];
  end
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS + 3; i++) vld_q[i] <= 1'b0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NS + 3; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      ed_q[0] <= in_edge_i;
      kd_q[0] <= in_kind_i;
      sd_q[0] <= in_side_i;
      r_q[0]  <= in_num_i;
      dn_q[0] <= in_den_i;
      qt_q[0] <= '0;
    end
  end

  for (genvar g = 1; g <= NS; g++) begin : g_div
    logic [NumW:0] sh;
    logic          ge;
    assign sh = {r_q[g-1], 1'b0};
    assign ge = sh >= {1'b0, dn_q[g-1]};
    always_ff @(posedge clk_i) begin
      if (adv[g] && vld_q[g-1]) begin
        ed_q[g] <= ed_q[g-1];
        kd_q[g] <= kd_q[g-1];
        sd_q[g] <= sd_q[g-1];
        dn_q[g] <= dn_q[g-1];
        r_q[g]  <= ge ? NumW'(sh - {1'b0, dn_q[g-1]}) : NumW'(sh);
        qt_q[g] <= {qt_q[g-1][FracBits-2:0], ge};
      end
    end
  end

  // Product stage.
  epi_pkg::edge_t            pe_q;
  epi_pkg::kind_e            pk_q;
  logic [epi_pkg::SideW-1:0] ps_q;
  logic signed [MW-1:0]      pm_q [3];
  logic signed [DW-1:0]      dx, dy, dz;
  logic signed [FracBits:0]  qs;

  assign dx = DW'(ed_q[NS].ex) - DW'(ed_q[NS].sx);
  assign dy = DW'(ed_q[NS].ey) - DW'(ed_q[NS].sy);
  assign dz = DW'(ed_q[NS].ez) - DW'(ed_q[NS].sz);
  assign qs = signed'({1'b0, qt_q[NS]});

  always_ff @(posedge clk_i) begin
    if (adv[NS+1] && vld_q[NS]) begin
      pe_q <= ed_q[NS];
      pk_q <= kd_q[NS];
      ps_q <= sd_q[NS];
      pm_q[0] <= MW'(dx) * MW'(qs);
      pm_q[1] <= MW'(dy) * MW'(qs);
      pm_q[2] <= MW'(dz) * MW'(qs);
    end
  end

  logic [epi_pkg::SideW-1:0] os_q;
  logic signed [CW-1:0]      ox_q, oy_q, oz_q;

  always_ff @(posedge clk_i) begin
    if (adv[NS+2] && vld_q[NS+1]) begin
      os_q <= ps_q;
      case (pk_q)
        epi_pkg::KindEnd: begin
          ox_q <= pe_q.ex;
          oy_q <= pe_q.ey;
          oz_q <= pe_q.ez;
        end
        epi_pkg::KindCross: begin
          ox_q <= pe_q.sx + CW'(pm_q[0] >>> FracBits);
          oy_q <= pe_q.sy + CW'(pm_q[1] >>> FracBits);
          oz_q <= pe_q.sz + CW'(pm_q[2] >>> FracBits);
        end
        default: begin
          ox_q <= '0;
          oy_q <= '0;
          oz_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = vld_q[NS+2];
  assign out_side_o  = os_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
endmodule

// ===== design/edge_plane_intersect_unit.sv =====
// Top level of the edge plane intersect unit.
//
//   Channel   Direction  Payload
//   cfg       in         idx (register index), data (32 bit)
//   edge      in         start_x..end_z, six Q16.16 coordinates
//   result    out        start_side, cross_x, cross_y, cross_z
//
// One edge may be transferred in every cycle while the result side does not
// stall; an edge passes through two front stages, the queue, one entry register,
// one divider stage per quotient bit, a product stage and the output register.
// Reset clears every valid flag and loads the plane registers with their
// defaults. A stall at the result side backs up the divider pipeline, then
// the queue, then the front part, stage by stage.
`timescale 1ns / 1ps
module edge_plane_intersect_unit #(
  parameter int unsigned FracBits = epi_pkg::FracBitsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  epi_if.sink   cfg,
  epi_if.sink   edge_in,
  epi_if.source result
);
  localparam int unsigned NumW = epi_pkg::PlaneW + 1;
  localparam int unsigned QW   = $bits(epi_pkg::edge_t) + 2 + epi_pkg::SideW + 2 * NumW;

  epi_pkg::plane_t plane_q;

  // Configuration: always ready, unknown indexes are dropped.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.nx  <= '0;
      plane_q.ny  <= '0;
      plane_q.nz  <= 32'sd65536;
      plane_q.d   <= '0;
      plane_q.tol <= 31'd66;
    end else if (cfg.valid) begin
      case (cfg.data.idx)
        epi_pkg::RegNormalX: plane_q.nx  <= cfg.data.data;
        epi_pkg::RegNormalY: plane_q.ny  <= cfg.data.data;
        epi_pkg::RegNormalZ: plane_q.nz  <= cfg.data.data;
        epi_pkg::RegOffset:  plane_q.d   <= cfg.data.data;
        epi_pkg::RegTol:     plane_q.tol <= cfg.data.data[epi_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  logic                      f_valid, f_ready;
  epi_pkg::edge_t            f_edge;
  epi_pkg::kind_e            f_kind;
  logic [epi_pkg::SideW-1:0] f_side;
  logic [NumW-1:0]           f_num, f_den;

  epi_front #(.FracBits(FracBits), .NumW(NumW)) u_front (
    .clk_i, .rst_ni,
    .plane_i     (plane_q),
    .in_valid_i  (edge_in.valid),
    .in_ready_o  (edge_in.ready),
    .in_edge_i   (edge_in.data),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_edge_o  (f_edge),
    .out_kind_o  (f_kind),
    .out_side_o  (f_side),
    .out_num_o   (f_num),
    .out_den_o   (f_den)
  );

  logic          q_valid, q_ready;
  logic [QW-1:0] q_out;

  epi_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_edge, f_kind, f_side, f_num, f_den}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_out)
  );

  epi_pkg::edge_t            b_edge;
  logic [1:0]                b_kind_raw;
  epi_pkg::kind_e            b_kind;
  logic [epi_pkg::SideW-1:0] b_side;
  logic [NumW-1:0]           b_num, b_den;
  assign {b_edge, b_kind_raw, b_side, b_num, b_den} = q_out;
  assign b_kind = epi_pkg::kind_e'(b_kind_raw);

  epi_back #(.FracBits(FracBits), .NumW(NumW)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_edge_i   (b_edge),
    .in_kind_i   (b_kind),
    .in_side_i   (b_side),
    .in_num_i    (b_num),
    .in_den_i    (b_den),
    .out_valid_o (result.valid),
    .out_ready_i (result.ready),
    .out_side_o  (result.data.start_side),
    .out_x_o     (result.data.cross_x),
    .out_y_o     (result.data.cross_y),
    .out_z_o     (result.data.cross_z)
  );
endmodule

// ===== bench/epi_bench_if.sv =====
// Payload types for the configuration and result channels of the test bench.
`timescale 1ns / 1ps
package epi_bench_pkg;

  typedef struct packed {
    logic [epi_pkg::CfgIdxW-1:0] idx;
    logic [31:0]                 data;
  } cfg_word_t;

  typedef struct packed {
    logic [epi_pkg::SideW-1:0]         start_side;
    logic signed [epi_pkg::CoordW-1:0] cross_x;
    logic signed [epi_pkg::CoordW-1:0] cross_y;
    logic signed [epi_pkg::CoordW-1:0] cross_z;
  } crossing_t;
endpackage

// ===== bench/edge_plane_intersect_unit_test.sv =====
// Self-checking test bench for the edge plane intersect unit.
`timescale 1ns / 1ps
module edge_plane_intersect_unit_test;

  localparam int unsigned FracBits = epi_pkg::FracBitsDefault;
  // Pipeline depth of the unit, plus a margin for draining.
  localparam int unsigned DrainCycles = FracBits + 6 + 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 400;
  // An index past the end of the register list.
  localparam logic [epi_pkg::CfgIdxW-1:0] RegUnused = 3'd5;

  logic clk_i;
  logic rst_ni;

  epi_if #(.T(epi_bench_pkg::cfg_word_t)) cfg_ch ();
  epi_if #(.T(epi_pkg::edge_t))           edge_ch ();
  epi_if #(.T(epi_bench_pkg::crossing_t)) result_ch ();

  edge_plane_intersect_unit #(.FracBits(FracBits)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch.sink),
    .edge_in(edge_ch.sink),
    .result (result_ch.source)
  );

  // Our own copy of the plane registers, updated on every accepted write.
  longint plane_a, plane_b, plane_c, plane_d, band_half;

  epi_bench_pkg::crossing_t crossings_due[$];
  int unsigned error_count;
  int unsigned edges_sent;
  int unsigned results_seen;
  int unsigned crossings_seen;
  int unsigned cycle_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  // Clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Plane value with each product floored to the fraction width.
  function automatic longint plane_value_at(longint x, longint y, longint z);
    return ((plane_a * x) >>> FracBits) + ((plane_b * y) >>> FracBits) +
           ((plane_c * z) >>> FracBits) + plane_d;
  endfunction

  function automatic int side_of(longint v);
    if (v < -band_half) return -1;
    if (v > band_half) return 1;
    return 0;
  endfunction

  // Works out the crossing for one edge under the current plane.
  function automatic epi_bench_pkg::crossing_t predict_crossing(epi_pkg::edge_t e);
    epi_bench_pkg::crossing_t res;
    longint s[3], f[3], c[3];
    longint v1, v2;
    longint unsigned num, den, rem, quo;
    int side1, side2;
    s[0] = e.sx; s[1] = e.sy; s[2] = e.sz;
    f[0] = e.ex; f[1] = e.ey; f[2] = e.ez;
    c[0] = 0; c[1] = 0; c[2] = 0;
    res.start_side = epi_pkg::SideNone;
    v1 = plane_value_at(s[0], s[1], s[2]);
    side1 = side_of(v1);
    if (side1 != 0) begin
      v2 = plane_value_at(f[0], f[1], f[2]);
      side2 = side_of(v2);
      if (side2 == 0) begin
        c = f;
        res.start_side = (side1 < 0) ? epi_pkg::SideNeg : epi_pkg::SidePos;
      end else if (side2 != side1) begin
        // Restoring division for the fraction of the way along the edge.
        num = (v1 < 0) ? -v1 : v1;
        den = num + ((v2 < 0) ? -v2 : v2);
        rem = num;
        quo = 0;
        for (int k = 0; k < FracBits; k++) begin
          rem = rem << 1;
          quo = quo << 1;
          if (rem >= den) begin
            rem = rem - den;
            quo = quo | 1;
          end
        end
        for (int i = 0; i < 3; i++)
          c[i] = s[i] + (((f[i] - s[i]) * longint'(quo)) >>> FracBits);
        res.start_side = (side1 < 0) ? epi_pkg::SideNeg : epi_pkg::SidePos;
      end
    end
    res.cross_x = c[0][31:0];
    res.cross_y = c[1][31:0];
    res.cross_z = c[2][31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Writes one plane register once the write channel takes it.
  task automatic write_plane_reg(logic [epi_pkg::CfgIdxW-1:0] idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{idx: idx, data: value};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      epi_pkg::RegNormalX: plane_a = longint'(signed'(value));
      epi_pkg::RegNormalY: plane_b = longint'(signed'(value));
      epi_pkg::RegNormalZ: plane_c = longint'(signed'(value));
      epi_pkg::RegOffset:  plane_d = longint'(signed'(value));
      epi_pkg::RegTol:     band_half = longint'(value[epi_pkg::TolW-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] tol);
    write_plane_reg(epi_pkg::RegNormalX, a);
    write_plane_reg(epi_pkg::RegNormalY, b);
    write_plane_reg(epi_pkg::RegNormalZ, c);
    write_plane_reg(epi_pkg::RegOffset, d);
    write_plane_reg(epi_pkg::RegTol, tol);
    // An index beyond the register list must leave the plane untouched.
    write_plane_reg(RegUnused, $urandom);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one edge, with random gaps, and records what it should produce.
  task automatic send_edge(epi_pkg::edge_t e, bit typed_in,
                           epi_bench_pkg::crossing_t typed_res);
    while ($urandom_range(99) < send_gap_pct) begin
      edge_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.data  <= e;
    @(posedge clk_i);
    while (!edge_ch.ready) @(posedge clk_i);
    crossings_due.push_back(typed_in ? typed_res : predict_crossing(e));
    edges_sent++;
  endtask

  task automatic wait_drained();
    edge_ch.valid <= 1'b0;
    while (crossings_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(int unsigned style);
    case (style)
      0: return $urandom;
      1: return 32'(signed'($urandom_range(2 * 65536 * 16)) - 65536 * 16);
      default: return 32'(signed'($urandom_range(1 << 15)) - (1 << 14));
    endcase
  endfunction

  // Random edges: mostly modest coordinates that land on both sides of the
  // plane, some near the plane and some fully random words.
  task automatic send_random_edges(int unsigned count);
    epi_pkg::edge_t e;
    int unsigned style;
    for (int n = 0; n < count; n++) begin
      style = $urandom_range(9);
      style = (style < 2) ? 0 : (style < 7) ? 1 : 2;
      e.sx = pick_coord(style); e.sy = pick_coord(style); e.sz = pick_coord(style);
      e.ex = pick_coord(style); e.ey = pick_coord(style); e.ez = pick_coord(style);
      // Push the ends apart along z half the time, except for fully random words, so that crossings are common.
      if ($urandom_range(1) == 1 && style != 0) begin
        e.sz = -e.ez;
      end
      send_edge(e, 1'b0, '0);
    end
  endtask

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    epi_bench_pkg::crossing_t want;
    epi_bench_pkg::crossing_t got;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (crossings_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = crossings_due.pop_front();
          results_seen++;
          if (want.start_side != epi_pkg::SideNone) crossings_seen++;
          if (got.start_side !== want.start_side)
            report_mismatch($sformatf("start_side %0d, want %0d",
                                      got.start_side, want.start_side));
          if (got.cross_x !== want.cross_x)
            report_mismatch($sformatf("cross_x %h, want %h", got.cross_x, want.cross_x));
          if (got.cross_y !== want.cross_y)
            report_mismatch($sformatf("cross_y %h, want %h", got.cross_y, want.cross_y));
          if (got.cross_z !== want.cross_z)
            report_mismatch($sformatf("cross_z %h, want %h", got.cross_z, want.cross_z));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[edge_plane_intersect_unit] ERROR");
      $finish;
    end
  end

  typedef struct {
    epi_pkg::edge_t           e;
    bit                       typed_in;
    epi_bench_pkg::crossing_t res;
  } edge_row_t;

  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [31:0] Min = 32'h8000_0000;
  localparam logic [31:0] Max = 32'h7FFF_FFFF;

  // Directed edges under the plane z = 0 with the default band of 66.
  edge_row_t directed_rows[] = '{
    // Start on the plane: no crossing.
    '{'{0, 0, 0, 0, 0, One}, 1'b1, '{epi_pkg::SideNone, 0, 0, 0}},
    // Ends on opposite sides, crossing half way.
    '{'{0, 0, -One, 0, 0, One}, 1'b1, '{epi_pkg::SideNeg, 0, 0, 0}},
    '{'{5, 7, One, 5, 7, -One}, 1'b0, '0},
    // End on the plane: the end point is the crossing.
    '{'{3, 4, One, 9, 11, 0}, 1'b1, '{epi_pkg::SidePos, 9, 11, 0}},
    '{'{3, 4, -One, Min, Max, 66}, 1'b1, '{epi_pkg::SideNeg, Min, Max, 66}},
    // Both ends on the same side.
    '{'{0, 0, One, 0, 0, 2 * One}, 1'b1, '{epi_pkg::SideNone, 0, 0, 0}},
    '{'{0, 0, -One, Max, Min, -67}, 1'b1, '{epi_pkg::SideNone, 0, 0, 0}},
    // Just inside and just outside the band.
    '{'{0, 0, 66, 0, 0, -One}, 1'b1, '{epi_pkg::SideNone, 0, 0, 0}},
    '{'{0, 0, -66, 0, 0, One}, 1'b1, '{epi_pkg::SideNone, 0, 0, 0}},
    '{'{0, 0, 67, 0, 0, -67}, 1'b0, '0},
    // Extreme coordinates.
    '{'{Min, Min, Min, Max, Max, Max}, 1'b0, '0},
    '{'{Max, Max, Max, Min, Min, Min}, 1'b0, '0},
    '{'{Max, Min, Max, Min, Max, Min}, 1'b0, '0},
    '{'{Max, Max, Max, Max, Max, Max}, 1'b1, '{epi_pkg::SideNone, 0, 0, 0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1}, 1'b1,
      '{epi_pkg::SideNone, 0, 0, 0}}
  };

  initial begin
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    edge_ch.valid = 1'b0;
    edge_ch.data = '0;
    result_ch.ready = 1'b0;
    error_count = 0;
    edges_sent = 0;
    results_seen = 0;
    crossings_seen = 0;
    cycle_count = 0;
    send_gap_pct = 9;
    recv_stall_pct = 79;
    plane_a = 0; plane_b = 0; plane_c = 65536; plane_d = 0; band_half = 66;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed edges against the plane left by reset; the sender seldom
    // idles and the receiver often stalls.
    foreach (directed_rows[i])
      send_edge(directed_rows[i].e, directed_rows[i].typed_in, directed_rows[i].res);
    wait_drained();

    // Same idling, zero band and random plane.
    load_plane(32'(signed'($urandom_range(4 * 65536)) - 2 * 65536),
               32'(signed'($urandom_range(4 * 65536)) - 2 * 65536),
               32'(signed'($urandom_range(4 * 65536)) - 2 * 65536),
               32'(signed'($urandom_range(1 << 20)) - (1 << 19)), 0);
    send_random_edges(RandomItems / 4);
    wait_drained();

    // Extreme plane words; the band write has its top bit set and is masked.
    load_plane(Min, Max, 32'hFFFF_FFFF, Max, 32'hFFFF_FFFF);
    send_random_edges(RandomItems / 12);
    wait_drained();
    load_plane(Max, Min, Min, Min, 32'h0000_0001);
    send_random_edges(RandomItems / 12);
    wait_drained();

    // Roles swapped: the sender idles often, the receiver seldom stalls.
    send_gap_pct = 79;
    recv_stall_pct = 9;
    load_plane(0, 0, One, 32'(signed'($urandom_range(1 << 14)) - (1 << 13)), 1 << 12);
    send_random_edges(RandomItems / 4);
    wait_drained();

    // Full rate on both sides with a random plane.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    load_plane($urandom, $urandom, $urandom, $urandom, $urandom_range(1 << 16));
    send_random_edges(RandomItems / 6);
    wait_drained();
    load_plane(32'(signed'($urandom_range(2 * 65536)) - 65536),
               32'(signed'($urandom_range(2 * 65536)) - 65536), One, 0, 66);
    send_random_edges(RandomItems / 6);
    wait_drained();

    $display("%0d edges sent, %0d results checked, %0d of them crossings",
             edges_sent, results_seen, crossings_seen);
    $display("six plane settings, including extreme words and zero and full bands");
    if (error_count == 0 && crossings_due.size() == 0) begin
      $display("[edge_plane_intersect_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, crossings_due.size());
      $display("[edge_plane_intersect_unit] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/epi_pkg.sv
design/epi_if.sv
design/epi_front.sv
design/epi_queue.sv
design/epi_back.sv
design/edge_plane_intersect_unit.sv
bench/epi_bench_if.sv
bench/edge_plane_intersect_unit_test.sv
